// ===== design/escc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and calendar helper functions for the epoch seconds converter.
// No dependencies.
package escc_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_DAYM,
        S_HOUR,
        S_MIN,
        S_SEC
    } t_state;

    // configuration register indexes
    localparam logic CfgEpoch  = 1'b0;
    localparam logic CfgLatest = 1'b1;

    localparam logic [11:0] EpochReset  = 12'd2000;
    localparam logic [11:0] LatestReset = 12'd2099;

    localparam logic [31:0] SecsDay      = 32'd86400;
    localparam logic [31:0] SecsHour     = 32'd3600;
    localparam logic [31:0] SecsMin      = 32'd60;
    localparam logic [31:0] SecsYear     = 32'd31536000;
    localparam logic [31:0] SecsLeapYear = 32'd31622400;

    // reciprocal of 25 scaled by 2^16, exact for all 12-bit years
    localparam logic [11:0] Recip25 = 12'd2622;

    // Gregorian leap rule; 100 = 4*25 and 400 = 16*25
    function automatic logic f_is_leap(input logic [11:0] y);
        logic [23:0] prod;
        logic [7:0]  q;
        logic [11:0] q25;
        logic        div25;
        prod  = {12'd0, y} * {12'd0, Recip25};
        q     = prod[23:16];
        q25   = ({4'd0, q} << 4) + ({4'd0, q} << 3) + {4'd0, q};
        div25 = (q25 == y);
        return (y[1:0] == 2'd0) && !(div25 && (y[3:0] != 4'd0));
    endfunction

    function automatic logic [31:0] f_year_secs(input logic leap);
        return leap ? SecsLeapYear : SecsYear;
    endfunction

    // months 0 and 13..15 count as zero days
    function automatic logic [31:0] f_month_secs(input logic leap, input logic [3:0] m);
        logic [31:0] s;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: s = 32'd2678400;
            4'd4, 4'd6, 4'd9, 4'd11:                    s = 32'd2592000;
            4'd2:    s = leap ? 32'd2505600 : 32'd2419200;
            default: s = 32'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== design/escc_alu.sv =====
`timescale 1ns / 1ps
// Shared 32-bit add / subtract unit with borrow flag used by the sequencer.
// Depends on nothing.
module escc_alu (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_sub,
    output logic [31:0] o_res,
    output logic        o_borrow
);
    logic [32:0] w_sum;

    always_comb begin
        if (i_sub) begin
            w_sum = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            w_sum = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_res    = w_sum[31:0];
    // for subtract, set when i_b > i_a
    assign o_borrow = i_sub & w_sum[32];
endmodule

// ===== design/epoch_seconds_calendar_converter.sv =====
`timescale 1ns / 1ps
// Top level: seconds count <-> Gregorian date converter, sequencer and datapath.
// Depends on escc_pkg and escc_alu.
//
// channel   direction  handshake                    payload
// command   in         start, busy                  i_mode, i_sec_count_in, i_cal_*, i_*_of_*
// result    out        o_result_valid (1 cycle)     o_out_*
// config    in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// One shared adder/subtractor does one year, month, day, hour or minute step per cycle.
// Count to date walks years, months (up to 12), days (up to 31), hours (up to 24) and minutes (up to 60),
// then takes the remainder as seconds. Date to count adds years, months, days, a day back off, hours, minutes, seconds.
// Reset clears the sequencer and loads 2000 / 2099 into the epoch / latest registers.
// The result strobe lasts one cycle; the receiver cannot stall. busy is low in that cycle.
module epoch_seconds_calendar_converter
    import escc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_sec_count_in,
    input  logic [11:0] i_cal_year,
    input  logic [3:0]  i_cal_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [4:0]  i_hour_of_day,
    input  logic [5:0]  i_minute_of_hour,
    input  logic [5:0]  i_second_of_minute,
    output logic        o_result_valid,
    output logic [31:0] o_out_sec_count,
    output logic [11:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [4:0]  o_out_hour,
    output logic [5:0]  o_out_minute,
    output logic [5:0]  o_out_second,
    output logic        o_out_leap,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    t_state      r_state, n_state;
    logic        r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_cnt, n_cnt;
    logic [11:0] r_iter, n_iter;
    logic        r_itleap, n_itleap;
    logic [11:0] r_year, n_year;
    logic        r_leap, n_leap;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic        r_done, n_done;
    logic [11:0] r_epoch, r_latest;

    logic [31:0] alu_b, alu_res;
    logic        alu_sub, alu_borrow;
    logic [11:0] iter_inc;
    logic [11:0] clamp_year;

    escc_alu u_alu (
        .i_a      (r_acc),
        .i_b      (alu_b),
        .i_sub    (alu_sub),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign iter_inc = r_iter + 12'd1;

    // raise to epoch first, then lower to latest
    always_comb begin
        clamp_year = i_cal_year;
        if (clamp_year < r_epoch) begin
            clamp_year = r_epoch;
        end
        if (clamp_year > r_latest) begin
            clamp_year = r_latest;
        end
    end

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch  <= EpochReset;
            r_latest <= LatestReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CfgEpoch:  r_epoch  <= i_cfg_data;
                CfgLatest: r_latest <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_iter   <= n_iter;
        r_itleap <= n_itleap;
        r_year   <= n_year;
        r_leap   <= n_leap;
        r_month  <= n_month;
        r_day    <= n_day;
        r_hour   <= n_hour;
        r_min    <= n_min;
        r_sec    <= n_sec;
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_iter   = r_iter;
        n_itleap = r_itleap;
        n_year   = r_year;
        n_leap   = r_leap;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;
        n_done   = 1'b0;
        alu_b    = 32'd0;
        alu_sub  = !r_mode;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode   = i_mode;
                    n_iter   = r_epoch;
                    n_itleap = f_is_leap(r_epoch);
                    if (!i_mode) begin
                        n_acc   = i_sec_count_in;
                        n_cnt   = i_sec_count_in;
                        n_month = 4'd1;
                        n_day   = 5'd1;
                        n_hour  = 5'd0;
                        n_min   = 6'd0;
                        n_sec   = 6'd0;
                    end else begin
                        n_acc   = 32'd0;
                        n_year  = clamp_year;
                        n_leap  = f_is_leap(clamp_year);
                        n_month = i_cal_month;
                        n_day   = i_day_of_month;
                        n_hour  = i_hour_of_day;
                        n_min   = i_minute_of_hour;
                        n_sec   = i_second_of_minute;
                    end
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                alu_b = f_year_secs(r_itleap);
                if (!r_mode) begin
                    if (!alu_borrow) begin
                        n_acc    = alu_res;
                        n_iter   = iter_inc;
                        n_itleap = f_is_leap(iter_inc);
                    end else begin
                        n_year  = r_iter;
                        n_leap  = r_itleap;
                        n_state = S_MONTH;
                    end
                end else begin
                    if (r_iter < r_year) begin
                        n_acc    = alu_res;
                        n_iter   = iter_inc;
                        n_itleap = f_is_leap(iter_inc);
                    end else begin
                        n_iter  = 12'd1;
                        n_state = S_MONTH;
                    end
                end
            end
            S_MONTH: begin
                if (!r_mode) begin
                    alu_b = f_month_secs(r_leap, r_month);
                    if ((r_month < 4'd12) && !alu_borrow) begin
                        n_acc   = alu_res;
                        n_month = r_month + 4'd1;
                    end else begin
                        n_state = S_DAY;
                    end
                end else begin
                    alu_b = f_month_secs(r_leap, r_iter[3:0]);
                    if (r_iter[3:0] < r_month) begin
                        n_acc  = alu_res;
                        n_iter = iter_inc;
                    end else begin
                        n_state = S_DAY;
                    end
                end
            end
            S_DAY: begin
                if (!r_mode) begin
                    alu_b = SecsDay;
                    if (!alu_borrow) begin
                        n_acc = alu_res;
                        n_day = r_day + 5'd1;
                    end else begin
                        n_state = S_HOUR;
                    end
                end else begin
                    alu_b   = {27'd0, r_day} * SecsDay;
                    n_acc   = alu_res;
                    n_state = S_DAYM;
                end
            end
            S_DAYM: begin
                // day of month is 1-based: take one day back off
                alu_sub = 1'b1;
                alu_b   = SecsDay;
                n_acc   = alu_res;
                n_state = S_HOUR;
            end
            S_HOUR: begin
                if (!r_mode) begin
                    alu_b = SecsHour;
                    if (!alu_borrow) begin
                        n_acc  = alu_res;
                        n_hour = r_hour + 5'd1;
                    end else begin
                        n_state = S_MIN;
                    end
                end else begin
                    alu_b   = {27'd0, r_hour} * SecsHour;
                    n_acc   = alu_res;
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (!r_mode) begin
                    alu_b = SecsMin;
                    if (!alu_borrow) begin
                        n_acc = alu_res;
                        n_min = r_min + 6'd1;
                    end else begin
                        n_sec   = r_acc[5:0];
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    alu_b   = {20'd0, 12'd60 * {6'd0, r_min}};
                    n_acc   = alu_res;
                    n_state = S_SEC;
                end
            end
            S_SEC: begin
                alu_b   = {26'd0, r_sec};
                n_acc   = alu_res;
                n_cnt   = alu_res;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_valid  = r_done;
    assign o_out_sec_count = r_cnt;
    assign o_out_year      = r_year;
    assign o_out_month     = r_month;
    assign o_out_day       = r_day;
    assign o_out_hour      = r_hour;
    assign o_out_minute    = r_min;
    assign o_out_second    = r_sec;
    assign o_out_leap      = r_leap;

    // busy is raised after an accepted start
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a conversion");

    // count to date always yields a normalized time of day and month
    a_mode0_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !r_mode |-> (o_out_month >= 4'd1) && (o_out_month <= 4'd12)
            && (o_out_hour < 5'd24) && (o_out_minute < 6'd60) && (o_out_second < 6'd60))
        else $error("count to date result out of range");

    a_mode1_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && r_mode |-> (o_out_year <= r_latest))
        else $error("clamped year above latest year");
endmodule

// ===== dv/epoch_calendar_checker.sv =====
`timescale 1ns / 1ps
// Checker for the epoch seconds converter: tracks register writes, predicts every
// accepted command and compares each result strobe against the oldest prediction.
// Depends on escc_pkg.
module epoch_calendar_checker
    import escc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_sec_count_in,
    input  logic [11:0] i_cal_year,
    input  logic [3:0]  i_cal_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [4:0]  i_hour_of_day,
    input  logic [5:0]  i_minute_of_hour,
    input  logic [5:0]  i_second_of_minute,
    input  logic        o_result_valid,
    input  logic [31:0] o_out_sec_count,
    input  logic [11:0] o_out_year,
    input  logic [3:0]  o_out_month,
    input  logic [4:0]  o_out_day,
    input  logic [4:0]  o_out_hour,
    input  logic [5:0]  o_out_minute,
    input  logic [5:0]  o_out_second,
    input  logic        o_out_leap,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] DaySecs  = 32'd86400;
    localparam logic [31:0] HourSecs = 32'd3600;
    localparam logic [31:0] MinSecs  = 32'd60;

    typedef struct {
        logic        mode;
        logic [31:0] sec_count;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_command;

    typedef struct {
        logic [31:0] sec_count;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        leap;
    } t_calendar;

    logic [11:0] base_year;
    logic [11:0] latest_year;
    t_calendar   expected_dates[$];

    function automatic logic gregorian_leap(input logic [11:0] y);
        return (y[1:0] == 2'd0) && ((y % 12'd100 != 12'd0) || (y % 12'd400 == 12'd0));
    endfunction

    function automatic logic [31:0] year_length(input logic [11:0] y);
        return gregorian_leap(y) ? DaySecs * 32'd366 : DaySecs * 32'd365;
    endfunction

    // out-of-range month numbers contribute nothing
    function automatic logic [31:0] month_length(input logic leap, input logic [3:0] m);
        logic [31:0] days;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 32'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    days = 32'd30;
            4'd2:    days = leap ? 32'd29 : 32'd28;
            default: days = 32'd0;
        endcase
        return days * DaySecs;
    endfunction

    function automatic t_calendar convert_calendar(input t_command c);
        t_calendar   r;
        logic [31:0] rest;
        logic [31:0] total;
        logic [11:0] y;
        logic [3:0]  m;
        int          yy;
        int          mm;
        if (c.mode == 1'b0) begin
            rest = c.sec_count;
            y = base_year;
            // year register is 12 bits and wraps past 4095
            while (rest >= year_length(y)) begin
                rest -= year_length(y);
                y += 12'd1;
            end
            r.leap = gregorian_leap(y);
            m = 4'd1;
            while (m < 4'd12 && rest >= month_length(r.leap, m)) begin
                rest -= month_length(r.leap, m);
                m += 4'd1;
            end
            r.sec_count = c.sec_count;
            r.year      = y;
            r.month     = m;
            r.day       = 5'(rest / DaySecs + 32'd1);
            rest        = rest % DaySecs;
            r.hour      = 5'(rest / HourSecs);
            rest        = rest % HourSecs;
            r.minute    = 6'(rest / MinSecs);
            r.second    = 6'(rest % MinSecs);
        end else begin
            // raise to epoch first, then lower to latest: latest wins when below epoch
            y = c.year;
            if (y < base_year) y = base_year;
            if (y > latest_year) y = latest_year;
            r.leap = gregorian_leap(y);
            total = 32'd0;
            for (yy = int'(base_year); yy < int'(y); yy++) total += year_length(12'(yy));
            for (mm = 1; mm < int'(c.month); mm++) total += month_length(r.leap, 4'(mm));
            total += DaySecs * ({27'd0, c.day} - 32'd1);
            total += HourSecs * {27'd0, c.hour};
            total += MinSecs * {26'd0, c.minute};
            total += {26'd0, c.second};
            r.sec_count = total;
            r.year      = y;
            r.month     = c.month;
            r.day       = c.day;
            r.hour      = c.hour;
            r.minute    = c.minute;
            r.second    = c.second;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            report_mismatch($sformatf("%s: expected %0d, got %0d", name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_calendar want;
        t_command  cmd;
        if (!i_rst_n) begin
            base_year    = EpochReset;
            latest_year  = LatestReset;
            o_fail_count = 0;
            expected_dates.delete();
            o_pending <= 0;
        end else begin
            // a result and the next command beat can share an edge: retire first
            if (o_result_valid) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, count %0d",
                                              o_out_sec_count));
                end else begin
                    want = expected_dates.pop_front();
                    check_field("sec_count", want.sec_count, o_out_sec_count);
                    check_field("year", 32'(want.year), 32'(o_out_year));
                    check_field("month", 32'(want.month), 32'(o_out_month));
                    check_field("day", 32'(want.day), 32'(o_out_day));
                    check_field("hour", 32'(want.hour), 32'(o_out_hour));
                    check_field("minute", 32'(want.minute), 32'(o_out_minute));
                    check_field("second", 32'(want.second), 32'(o_out_second));
                    check_field("leap", 32'(want.leap), 32'(o_out_leap));
                end
            end
            if (start && !busy) begin
                cmd.mode      = i_mode;
                cmd.sec_count = i_sec_count_in;
                cmd.year      = i_cal_year;
                cmd.month     = i_cal_month;
                cmd.day       = i_day_of_month;
                cmd.hour      = i_hour_of_day;
                cmd.minute    = i_minute_of_hour;
                cmd.second    = i_second_of_minute;
                expected_dates.push_back(convert_calendar(cmd));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CfgEpoch:  base_year = i_cfg_data;
                    CfgLatest: latest_year = i_cfg_data;
                    default: ;
                endcase
            end
            o_pending <= expected_dates.size();
        end
    end

endmodule

// ===== dv/tb_epoch_seconds_calendar_converter.sv =====
`timescale 1ns / 1ps
// Testbench top for the epoch seconds converter: clock, reset, command and register
// stimulus over several year windows, and the verdict. Depends on escc_pkg,
// epoch_calendar_checker and the converter RTL.
module tb_epoch_seconds_calendar_converter;
    import escc_pkg::*;

    localparam int CycleLimit = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_mode = 1'b0;
    logic [31:0] i_sec_count_in = '0;
    logic [11:0] i_cal_year = '0;
    logic [3:0]  i_cal_month = '0;
    logic [4:0]  i_day_of_month = '0;
    logic [4:0]  i_hour_of_day = '0;
    logic [5:0]  i_minute_of_hour = '0;
    logic [5:0]  i_second_of_minute = '0;
    logic        o_result_valid;
    logic [31:0] o_out_sec_count;
    logic [11:0] o_out_year;
    logic [3:0]  o_out_month;
    logic [4:0]  o_out_day;
    logic [4:0]  o_out_hour;
    logic [5:0]  o_out_minute;
    logic [5:0]  o_out_second;
    logic        o_out_leap;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CfgEpoch;
    logic [11:0] i_cfg_data = '0;

    int fail_total;
    int pending_results;
    int cycle_count = 0;
    int cur_epoch = 2000;
    int cur_latest = 2099;
    bit steady = 1'b0;

    epoch_seconds_calendar_converter u_top (.*);

    epoch_calendar_checker u_checker (
        .o_fail_count(fail_total),
        .o_pending(pending_results),
        .*
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("epoch_seconds_calendar_converter verification failed");
            $finish;
        end
    end

    // random sender idle before a command beat; sometimes long enough to land mid-conversion
    task automatic sender_gap();
        int n;
        n = 0;
        if (!steady) begin
            while ($urandom_range(99) < 37) n++;
            if ($urandom_range(19) == 0) n += $urandom_range(300);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // start stays high on return so a following beat can go out without a drop
    task automatic send_command(input logic md, input logic [31:0] cnt, input logic [11:0] y,
                                input logic [3:0] m, input logic [4:0] d, input logic [4:0] h,
                                input logic [5:0] mi, input logic [5:0] s);
        sender_gap();
        start              <= 1'b1;
        i_mode             <= md;
        i_sec_count_in     <= cnt;
        i_cal_year         <= y;
        i_cal_month        <= m;
        i_day_of_month     <= d;
        i_hour_of_day      <= h;
        i_minute_of_hour   <= mi;
        i_second_of_minute <= s;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_window(input int epoch, input int latest);
        drain();
        write_reg(CfgEpoch, 12'(epoch));
        write_reg(CfgLatest, 12'(latest));
        i_cfg_valid <= 1'b0;
        cur_epoch  = epoch;
        cur_latest = latest;
    endtask

    task automatic random_items(input int n, input int pause_at);
        int          k;
        int          lo;
        int          hi;
        int          days;
        int          pick;
        logic [31:0] cnt;
        logic [31:0] secs;
        logic [11:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [4:0]  h;
        logic [5:0]  mi;
        logic [5:0]  s;
        lo = (cur_epoch < cur_latest ? cur_epoch : cur_latest) - 5;
        hi = (cur_epoch > cur_latest ? cur_epoch : cur_latest) + 5;
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        for (k = 0; k < n; k++) begin
            if (k == pause_at) drain();
            pick = $urandom_range(9);
            days = (pick < 6) ? $urandom_range(49710) : $urandom_range(800);
            case ($urandom_range(2))
                0:       secs = 32'd0;
                1:       secs = 32'd86399;
                default: secs = $urandom_range(86399);
            endcase
            cnt = (pick < 3) ? $urandom() : 32'(days) * 32'd86400 + secs;
            y   = ($urandom_range(4) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(hi, lo));
            m   = ($urandom_range(6) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
            d   = ($urandom_range(6) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(31, 1));
            h   = ($urandom_range(6) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
            mi  = ($urandom_range(6) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
            s   = ($urandom_range(6) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
            send_command(1'($urandom_range(1)), cnt, y, m, d, h, mi, s);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window 2000..2099: boundaries and clamping
        send_command(1'b0, 32'd0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b0, 32'hFFFF_FFFF, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b0, 32'd31 * 32'd86400, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b0, 32'd59 * 32'd86400, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b0, 32'd60 * 32'd86400, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b0, 32'd366 * 32'd86400 - 1, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b0, 32'd366 * 32'd86400, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b0, 32'd1520 * 32'd86400, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b1, 32'd0, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
        send_command(1'b1, 32'd0, 12'd1990, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30);
        send_command(1'b1, 32'd0, 12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_command(1'b1, 32'd0, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_command(1'b1, 32'd0, 12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
        send_command(1'b1, 32'd0, 12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
        send_command(1'b1, 32'd0, 12'd2001, 4'd0, 5'd10, 5'd1, 6'd1, 6'd1);
        send_command(1'b1, 32'd0, 12'd2002, 4'd13, 5'd10, 5'd1, 6'd1, 6'd1);
        send_command(1'b1, 32'd0, 12'd2003, 4'd15, 5'd10, 5'd1, 6'd1, 6'd1);
        send_command(1'b1, 32'd0, 12'd2004, 4'd5, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b1, 32'd0, 12'd2005, 4'd7, 5'd20, 5'd31, 6'd63, 6'd63);
        send_command(1'b1, 32'd0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b1, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F);
        random_items(380, 190);

        set_window(1970, 2235);
        random_items(250, -1);
        // latest below epoch: clamp lands under the epoch
        set_window(2100, 1970);
        random_items(150, -1);
        // year counter wraps past 4095 in count to date
        set_window(4090, 4095);
        send_command(1'b0, 32'hFFFF_FFFF, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_command(1'b1, 32'd0, 12'd4095, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0);
        random_items(150, -1);
        // full year span: date to count walks up to 4095 years, keep it short
        set_window(0, 4095);
        random_items(15, -1);
        set_window(4095, 0);
        random_items(100, -1);
        steady = 1'b1;
        set_window(1970, 2100);
        random_items(300, -1);
        steady = 1'b0;
        set_window(0, 0);
        random_items(100, -1);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_total == 0 && pending_results == 0) begin
            $display("epoch_seconds_calendar_converter verification clean");
        end else begin
            $display("epoch_seconds_calendar_converter verification failed");
        end
        $finish;
    end

endmodule
